// File: hw/rtl/cwss_pkg.sv
// Shared constants and types for the capability weighted server select unit.
// No dependencies.
package cwss_pkg;
  localparam int NumServers = 16;
  localparam int IdxW = 4;
  localparam int CapW = 32;
  localparam int PriW = 16;
  localparam int WgtW = 16;
  localparam int RejW = NumServers + 1;
  localparam int SumW = WgtW + IdxW;
  localparam int RndW = 32;
  localparam int PopW = 6;
  localparam int OutIdxW = 5;
  localparam logic [WgtW-1:0] FallbackWeight = 16'd100;
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdSelect = 1'b1;

  typedef struct packed {
    logic start;
    logic [SumW-1:0] divisor;
  } mod_req_t;

  function automatic logic [PopW-1:0] popcount(input logic [CapW-1:0] v);
    logic [PopW-1:0] n;
    n = '0;
    for (int i = 0; i < CapW; i++) n = n + PopW'(v[i]);
    return n;
  endfunction
endpackage

// File: hw/rtl/cwss_mod.sv
// Bit-serial restoring modulo unit: remainder of the random word by the weight sum.
// Depends on cwss_pkg.
module cwss_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cwss_pkg::mod_req_t          req,
  input  logic [cwss_pkg::RndW-1:0]   dividend,
  output logic                        done,
  output logic [cwss_pkg::SumW-1:0]   remainder
);
  logic [cwss_pkg::RndW-1:0] q_r;
  logic [cwss_pkg::SumW:0]   rem_r;
  logic [cwss_pkg::SumW-1:0] div_r;
  logic [5:0]                cnt_r;
  logic                      busy_r;
  logic [cwss_pkg::SumW:0]   sh;

  assign sh = {rem_r[cwss_pkg::SumW-1:0], q_r[cwss_pkg::RndW-1]};
  assign remainder = rem_r[cwss_pkg::SumW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        q_r    <= dividend;
        rem_r  <= '0;
        div_r  <= req.divisor;
        cnt_r  <= 6'(cwss_pkg::RndW);
      end else if (busy_r) begin
        q_r <= q_r << 1;
        if (sh >= {1'b0, div_r}) rem_r <= sh - {1'b0, div_r};
        else rem_r <= sh;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/capability_weighted_server_select_unit.sv
// Capability weighted server select unit: slot table, sequencer, modulo unit.
// Writes complete without leaving idle; select requests are handled one at a time.
// The sequencer steps one slot per cycle through three passes; the modulo unit is bit-serial.
// A new request is taken only while idle; busy is high while a request is in progress.
// Reset (synchronous, rst_n low) clears all slot valid bits and the sequencer.
// The receiver cannot stall: out_strobe marks each result for one cycle.
module capability_weighted_server_select_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [3:0]                    in_entry_index,
  input  logic                          in_entry_valid,
  input  logic [31:0]                   in_entry_caps,
  input  logic [15:0]                   in_entry_priority,
  input  logic [15:0]                   in_entry_weight,
  input  logic [31:0]                   in_mandatory_mask,
  input  logic [31:0]                   in_optional_mask,
  input  logic [16:0]                   in_reject_mask,
  input  logic [31:0]                   in_random_value,
  output logic                          out_strobe,
  output logic                          out_found,
  output logic [4:0]                    out_server_index,
  output logic [15:0]                   out_server_priority,
  output logic [15:0]                   out_server_weight
);
  typedef enum logic [2:0] {S_IDLE, S_PASS1, S_PASS2, S_MOD, S_WALK, S_OUT} state_t;

  logic [cwss_pkg::NumServers-1:0] valid_r;
  logic [cwss_pkg::CapW-1:0] caps_r [cwss_pkg::NumServers];
  logic [cwss_pkg::PriW-1:0] pri_r  [cwss_pkg::NumServers];
  logic [cwss_pkg::WgtW-1:0] wgt_r  [cwss_pkg::NumServers];

  state_t                    state_r;
  logic [cwss_pkg::IdxW-1:0] i_r;
  logic [31:0]               mand_r, opt_r;
  logic [cwss_pkg::RejW-1:0] rej_r;
  logic [31:0]               rnd_r;
  logic                      have_r;
  logic [cwss_pkg::PopW-1:0] best_opt_r;
  logic [cwss_pkg::PriW-1:0] best_pri_r;
  logic [cwss_pkg::SumW-1:0] sum_r, acc_r;
  logic [cwss_pkg::IdxW-1:0] first_r, pick_r;
  logic                      multi_r, mod_wait_r;
  logic [cwss_pkg::SumW-1:0] r_r;

  logic [cwss_pkg::CapW-1:0] cur_caps;
  logic [cwss_pkg::PriW-1:0] cur_pri;
  logic [cwss_pkg::WgtW-1:0] cur_wgt;
  logic [cwss_pkg::PopW-1:0] cur_n;
  logic                      elig, kept;
  logic [cwss_pkg::SumW-1:0] acc_nxt;
  cwss_pkg::mod_req_t        mreq;
  logic                      mdone;
  logic [cwss_pkg::SumW-1:0] mrem;

  assign cur_caps = caps_r[i_r];
  assign cur_pri  = pri_r[i_r];
  assign cur_wgt  = wgt_r[i_r];
  assign cur_n    = cwss_pkg::popcount(cur_caps & opt_r);
  assign elig     = valid_r[i_r] && !rej_r[i_r] && ((cur_caps & mand_r) == mand_r);
  assign kept     = elig && cur_n == best_opt_r && cur_pri == best_pri_r;
  assign acc_nxt  = acc_r + cwss_pkg::SumW'(cur_wgt);
  assign busy     = state_r != S_IDLE;

  assign mreq.start   = state_r == S_MOD && !mod_wait_r;
  assign mreq.divisor = sum_r;

  cwss_mod u_mod (
    .clk(clk), .rst_n(rst_n), .req(mreq), .dividend(rnd_r),
    .done(mdone), .remainder(mrem)
  );

  always_ff @(posedge clk) begin
    if (start && !busy && in_cmd == cwss_pkg::CmdWrite) begin
      caps_r[in_entry_index] <= in_entry_caps;
      pri_r[in_entry_index]  <= in_entry_priority;
      wgt_r[in_entry_index]  <= in_entry_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      out_strobe <= 1'b0;
      mod_wait_r <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_cmd == cwss_pkg::CmdWrite) begin
              valid_r[in_entry_index] <= in_entry_valid;
            end else begin
              mand_r <= in_mandatory_mask;
              opt_r  <= in_optional_mask;
              rej_r  <= in_reject_mask;
              rnd_r  <= in_random_value;
              i_r    <= '0;
              have_r <= 1'b0;
              sum_r  <= '0;
              acc_r  <= '0;
              multi_r <= 1'b0;
              if (valid_r == '0) begin
                out_strobe <= 1'b1;
                if (in_mandatory_mask == '0 && !in_reject_mask[cwss_pkg::NumServers]) begin
                  out_found           <= 1'b1;
                  out_server_index    <= cwss_pkg::OutIdxW'(cwss_pkg::NumServers);
                  out_server_priority <= '0;
                  out_server_weight   <= cwss_pkg::FallbackWeight;
                end else begin
                  out_found <= 1'b0; out_server_index <= '0;
                  out_server_priority <= '0; out_server_weight <= '0;
                end
              end else begin
                state_r <= S_PASS1;
              end
            end
          end
        end
        S_PASS1: begin
          if (elig && (!have_r || cur_n > best_opt_r ||
              (cur_n == best_opt_r && cur_pri < best_pri_r))) begin
            have_r     <= 1'b1;
            best_opt_r <= cur_n;
            best_pri_r <= cur_pri;
          end
          i_r <= i_r + 1'b1;
          if (i_r == cwss_pkg::IdxW'(cwss_pkg::NumServers - 1)) begin
            if (!(have_r || elig)) begin
              out_strobe <= 1'b1;
              out_found <= 1'b0; out_server_index <= '0;
              out_server_priority <= '0; out_server_weight <= '0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_PASS2;
            end
          end
        end
        S_PASS2: begin
          if (kept) begin
            if (!have_r) multi_r <= 1'b1;
            else first_r <= i_r;
            have_r <= 1'b0;
            sum_r  <= acc_nxt;
            acc_r  <= acc_nxt;
          end
          i_r <= i_r + 1'b1;
          if (i_r == cwss_pkg::IdxW'(cwss_pkg::NumServers - 1)) begin
            acc_r <= '0;
            if (kept) sum_r <= acc_nxt;
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          pick_r <= first_r;
          if (!multi_r || sum_r == '0) begin
            state_r <= S_OUT;
          end else if (!mod_wait_r) begin
            mod_wait_r <= 1'b1;
          end else if (mdone) begin
            mod_wait_r <= 1'b0;
            r_r     <= mrem;
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (kept) acc_r <= acc_nxt;
          if (kept && acc_nxt > r_r) begin
            pick_r  <= i_r;
            state_r <= S_OUT;
          end else begin
            i_r <= i_r + 1'b1;
            if (i_r == cwss_pkg::IdxW'(cwss_pkg::NumServers - 1)) state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_strobe          <= 1'b1;
          out_found           <= 1'b1;
          out_server_index    <= {1'b0, pick_r};
          out_server_priority <= pri_r[pick_r];
          out_server_weight   <= wgt_r[pick_r];
          state_r             <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) == S_OUT || $past(state_r) == S_PASS1 ||
                   $past(state_r) == S_IDLE) else $error("strobe from bad state");
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == cwss_pkg::CmdWrite) |=> !out_strobe)
    else $error("write produced result");
  a_fallback_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_server_index[4]) |-> out_found && out_server_weight == 16'd100)
    else $error("bad fallback result");
`endif
endmodule

// File: test/tb_capability_weighted_server_select_unit.sv
// Testbench for the capability weighted server select unit: directed and random
// table writes and selections, checked against an in-bench scoreboard.
// Depends on cwss_pkg and the unit's RTL.
`timescale 1ns / 1ps

class select_scoreboard;
  logic            tbl_valid[16];
  logic [31:0]     tbl_caps[16];
  logic [15:0]     tbl_pri[16];
  logic [15:0]     tbl_wgt[16];
  logic            exp_found[$];
  logic [4:0]      exp_idx[$];
  logic [15:0]     exp_pri[$];
  logic [15:0]     exp_wgt[$];
  int              errors;
  int              selects;

  function new();
    for (int i = 0; i < 16; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_caps[i] = '0;
      tbl_pri[i] = '0;
      tbl_wgt[i] = '0;
    end
    errors = 0;
    selects = 0;
  endfunction

  function automatic int pending();
    return exp_found.size();
  endfunction

  function automatic bit eligible(int i, logic [31:0] mand, logic [16:0] rej);
    return tbl_valid[i] && !rej[i] && ((tbl_caps[i] & mand) == mand);
  endfunction

  function automatic void note_request(logic cmd, logic [3:0] idx, logic vld,
                                       logic [31:0] caps, logic [15:0] pri,
                                       logic [15:0] wgt, logic [31:0] mand,
                                       logic [31:0] opt, logic [16:0] rej,
                                       logic [31:0] rnd);
    bit any_valid, have;
    int best_opt, n, count, first, pick;
    logic [15:0] best_pri;
    logic [31:0] sum, acc, r;
    logic f;
    logic [4:0] oi;
    logic [15:0] op, ow;
    if (cmd == cwss_pkg::CmdWrite) begin
      tbl_valid[idx] = vld;
      tbl_caps[idx] = caps;
      tbl_pri[idx] = pri;
      tbl_wgt[idx] = wgt;
      return;
    end
    selects++;
    any_valid = 0; have = 0; best_opt = 0; best_pri = 0;
    count = 0; first = 0; sum = 0; acc = 0;
    f = 0; oi = 0; op = 0; ow = 0;
    for (int i = 0; i < 16; i++) if (tbl_valid[i]) any_valid = 1;
    if (!any_valid) begin
      if (mand == 0 && !rej[16]) begin
        f = 1; oi = 5'd16; op = 0; ow = cwss_pkg::FallbackWeight;
      end
    end else begin
      for (int i = 0; i < 16; i++) begin
        if (!eligible(i, mand, rej)) continue;
        n = $countones(tbl_caps[i] & opt);
        if (!have || n > best_opt || (n == best_opt && tbl_pri[i] < best_pri)) begin
          have = 1; best_opt = n; best_pri = tbl_pri[i];
        end
      end
      if (have) begin
        for (int i = 0; i < 16; i++) begin
          if (!eligible(i, mand, rej)) continue;
          if ($countones(tbl_caps[i] & opt) != best_opt || tbl_pri[i] != best_pri) continue;
          if (count == 0) first = i;
          count++;
          sum += tbl_wgt[i];
        end
        pick = first;
        if (count > 1 && sum != 0) begin
          r = rnd % sum;
          for (int i = 0; i < 16; i++) begin
            if (!eligible(i, mand, rej)) continue;
            if ($countones(tbl_caps[i] & opt) != best_opt || tbl_pri[i] != best_pri)
              continue;
            acc += tbl_wgt[i];
            if (acc > r) begin
              pick = i;
              break;
            end
          end
        end
        f = 1; oi = pick[4:0]; op = tbl_pri[pick]; ow = tbl_wgt[pick];
      end
    end
    exp_found = {exp_found, f};
    exp_idx = {exp_idx, oi};
    exp_pri = {exp_pri, op};
    exp_wgt = {exp_wgt, ow};
  endfunction

  function automatic void check_result(logic f, logic [4:0] oi, logic [15:0] op,
                                       logic [15:0] ow);
    logic ef;
    logic [4:0] ei;
    logic [15:0] ep, ew;
    if (exp_found.size() == 0) begin
      $display("%0t: unexpected result found=%0d idx=%0d", $time, f, oi);
      errors++;
      return;
    end
    ef = exp_found.pop_front();
    ei = exp_idx.pop_front();
    ep = exp_pri.pop_front();
    ew = exp_wgt.pop_front();
    if (f !== ef) begin
      $display("%0t: found expected %0d actual %0d", $time, ef, f);
      errors++;
    end
    if (oi !== ei) begin
      $display("%0t: server_index expected %0d actual %0d", $time, ei, oi);
      errors++;
    end
    if (op !== ep) begin
      $display("%0t: server_priority expected %0d actual %0d", $time, ep, op);
      errors++;
    end
    if (ow !== ew) begin
      $display("%0t: server_weight expected %0d actual %0d", $time, ew, ow);
      errors++;
    end
  endfunction
endclass

module tb_capability_weighted_server_select_unit;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_cmd = 1'b0;
  logic [3:0]  in_entry_index = '0;
  logic        in_entry_valid = 1'b0;
  logic [31:0] in_entry_caps = '0;
  logic [15:0] in_entry_priority = '0;
  logic [15:0] in_entry_weight = '0;
  logic [31:0] in_mandatory_mask = '0;
  logic [31:0] in_optional_mask = '0;
  logic [16:0] in_reject_mask = '0;
  logic [31:0] in_random_value = '0;
  logic        out_strobe;
  logic        out_found;
  logic [4:0]  out_server_index;
  logic [15:0] out_server_priority;
  logic [15:0] out_server_weight;

  select_scoreboard sb;
  int cycles = 0;
  int writes_sent = 0;
  localparam int CycleLimit = 600000;

  always #5 clk = ~clk;

  capability_weighted_server_select_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_entry_index(in_entry_index), .in_entry_valid(in_entry_valid),
    .in_entry_caps(in_entry_caps), .in_entry_priority(in_entry_priority),
    .in_entry_weight(in_entry_weight), .in_mandatory_mask(in_mandatory_mask),
    .in_optional_mask(in_optional_mask), .in_reject_mask(in_reject_mask),
    .in_random_value(in_random_value), .out_strobe(out_strobe), .out_found(out_found),
    .out_server_index(out_server_index), .out_server_priority(out_server_priority),
    .out_server_weight(out_server_weight)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result(out_found, out_server_index, out_server_priority, out_server_weight);
  end

  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 2) == 0) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // hold start until the unit takes the request
  task automatic send(logic cmd, logic [3:0] idx, logic vld, logic [31:0] caps,
                      logic [15:0] pri, logic [15:0] wgt, logic [31:0] mand,
                      logic [31:0] opt, logic [16:0] rej, logic [31:0] rnd);
    @(negedge clk);
    in_cmd <= cmd; in_entry_index <= idx; in_entry_valid <= vld;
    in_entry_caps <= caps; in_entry_priority <= pri; in_entry_weight <= wgt;
    in_mandatory_mask <= mand; in_optional_mask <= opt;
    in_reject_mask <= rej; in_random_value <= rnd;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(cmd, idx, vld, caps, pri, wgt, mand, opt, rej, rnd);
    if (cmd == cwss_pkg::CmdWrite) writes_sent++;
  endtask

  task automatic wr(logic [3:0] idx, logic vld, logic [31:0] caps, logic [15:0] pri,
                    logic [15:0] wgt);
    send(cwss_pkg::CmdWrite, idx, vld, caps, pri, wgt,
         $urandom, $urandom, 17'($urandom_range(0, 17'h1ffff)), $urandom);
  endtask

  task automatic sel(logic [31:0] mand, logic [31:0] opt, logic [16:0] rej,
                     logic [31:0] rnd);
    send(cwss_pkg::CmdSelect, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
         $urandom, 16'($urandom), 16'($urandom), mand, opt, rej, rnd);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] small_caps();
    return {4'($urandom_range(0, 15)), 12'h0, 4'($urandom_range(0, 15)), 12'h0} |
           32'($urandom_range(0, 15));
  endfunction

  initial begin
    logic [31:0] m;
    sb = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table: fallback, rejected fallback, mandatory blocks fallback
    sel(32'h0, 32'hffffffff, 17'h0, 32'hffffffff);
    sel(32'h0, 32'h0, 17'h10000, 32'h0);
    sel(32'h1, 32'h0, 17'h0, 32'h0);
    wr(4'd0, 1'b1, 32'hffffffff, 16'hffff, 16'hffff);
    wr(4'd15, 1'b1, 32'h0, 16'h0, 16'h0);
    sel(32'h0, 32'h0, 17'h0, 32'h0);
    sel(32'hffffffff, 32'hffffffff, 17'h0, 32'h12345678);
    sel(32'h0, 32'hffffffff, 17'h0001, 32'h0);
    sel(32'h0, 32'h0, 17'h1ffff, 32'h0);
    wr(4'd15, 1'b1, 32'h0, 16'hffff, 16'h0);
    wr(4'd3, 1'b1, 32'h0, 16'hffff, 16'h0);
    sel(32'h0, 32'h0, 17'h0, 32'hffffffff);
    wr(4'd3, 1'b1, 32'h0, 16'hffff, 16'd7);
    wr(4'd15, 1'b1, 32'h0, 16'hffff, 16'd9);
    sel(32'h0, 32'h0, 17'h0, 32'd6);
    sel(32'h0, 32'h0, 17'h0, 32'd7);
    sel(32'h0, 32'h0, 17'h0, 32'hffffffff);
    for (int i = 0; i < 16; i++) wr(i[3:0], 1'b0, 32'h0, 16'h0, 16'h0);
    sel(32'h0, 32'h0, 17'h0, 32'h0);
    drain();

    for (int k = 0; k < 580; k++) begin
      idle_gap();
      if (k == 300) drain();
      if ($urandom_range(0, 1) == 0)
        wr(4'($urandom_range(0, 15)), $urandom_range(0, 4) != 0,
           ($urandom_range(0, 3) == 0) ? $urandom : small_caps(),
           ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)),
           ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)));
      else begin
        m = ($urandom_range(0, 2) == 0) ? 32'h0 : (small_caps() & $urandom);
        sel(m, ($urandom_range(0, 3) == 0) ? $urandom : small_caps(),
            ($urandom_range(0, 1) == 0) ? 17'h0 : 17'($urandom),
            $urandom);
      end
    end

    drain();
    repeat (100) @(negedge clk);
    $display("covered %0d table writes and %0d selections with random gaps",
             writes_sent, sb.selects);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
